### hdl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue cell chain.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [COUNT_W-1:0]           count_t;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE      = 2'd0,
        ST_FULL_DROP = 2'd1,
        ST_EMPTY_POP = 2'd2
    } status_t;

    // broadcast command to every cell
    typedef struct packed
    {
        logic  push_en;
        logic  pop_en;
        data_t value;
    } cmd_t;

    // what one cell shows its neighbors
    typedef struct packed
    {
        data_t value;
        logic  valid;
        logic  yield;
    } link_t;

endpackage

### hdl/mhpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted chain: holds one entry, shifts right on insert and
// left on removal.
// ----------------------------------------------------------------------------
module mhpq_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  mhpq_pkg::cmd_t cmd,
    input  mhpq_pkg::link_t left,
    input  mhpq_pkg::link_t right,
    output mhpq_pkg::link_t self
);

    mhpq_pkg::data_t value_reg;
    mhpq_pkg::data_t value_next;
    logic            valid_reg;
    logic            valid_next;
    logic            yield;

    // yield this slot when it is empty or the new item outranks what it holds
    assign yield = !valid_reg || (value_reg < cmd.value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (cmd.pop_en)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
        else if (cmd.push_en)
        begin
            if (left.yield)
            begin
                value_next = left.value;
                valid_next = left.valid;
            end
            else if (yield)
            begin
                value_next = cmd.value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign self.value = value_reg;
    assign self.valid = valid_reg;
    assign self.yield = yield;

endmodule

### hdl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Bounded priority queue of signed values kept as a sorted chain of cells;
// the head cell always holds the maximum.
// Result strobe: done is registered from busy, which is registered on accept.
// A new request is not accepted while busy; every cell of the chain shifts on the same edge.
// The receiver cannot stall; busy covers the cycle in which the chain shifts.
// Reset: queue empty, busy and done low.
// ----------------------------------------------------------------------------
module max_heap_priority_queue
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               operation,
    input  logic signed [mhpq_pkg::DATA_WIDTH-1:0] value,
    output logic                               busy,
    output logic                               done,
    output logic signed [mhpq_pkg::DATA_WIDTH-1:0] top_value,
    output logic                               is_empty,
    output logic [mhpq_pkg::COUNT_W-1:0]       entry_count,
    output logic [1:0]                         status
);

    mhpq_pkg::cmd_t    cmd_reg;
    mhpq_pkg::cmd_t    cmd_next;
    logic              busy_reg;
    logic              done_reg;
    mhpq_pkg::count_t  count_reg;
    mhpq_pkg::count_t  count_next;
    mhpq_pkg::status_t status_reg;
    mhpq_pkg::status_t status_next;
    logic              accept;
    logic              is_full;
    logic              no_entry;

    mhpq_pkg::link_t   cell_links [mhpq_pkg::CAPACITY];
    mhpq_pkg::link_t   head_link;
    mhpq_pkg::link_t   tail_link;
    mhpq_pkg::cmd_t    cell_cmd;

    assign accept   = start && !busy_reg;
    assign is_full  = (count_reg == mhpq_pkg::count_t'(mhpq_pkg::CAPACITY));
    assign no_entry = (count_reg == '0);

    always_comb
    begin
        cmd_next    = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            cmd_next.value = value;
            status_next    = mhpq_pkg::ST_DONE;
            if (mhpq_pkg::op_t'(operation) == mhpq_pkg::OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = mhpq_pkg::ST_FULL_DROP;
                end
                else
                begin
                    cmd_next.push_en = 1'b1;
                    count_next       = count_reg + mhpq_pkg::count_t'(1);
                end
            end
            else
            begin
                if (no_entry)
                begin
                    status_next = mhpq_pkg::ST_EMPTY_POP;
                end
                else
                begin
                    cmd_next.pop_en = 1'b1;
                    count_next      = count_reg - mhpq_pkg::count_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= mhpq_pkg::ST_DONE;
            cmd_reg    <= '0;
        end
        else
        begin
            busy_reg   <= accept;
            done_reg   <= busy_reg;
            count_reg  <= count_next;
            status_reg <= status_next;
            cmd_reg    <= cmd_next;
        end
    end

    // shift the chain only in the cycle after accept
    assign cell_cmd.push_en = cmd_reg.push_en && busy_reg;
    assign cell_cmd.pop_en  = cmd_reg.pop_en && busy_reg;
    assign cell_cmd.value   = cmd_reg.value;

    // virtual slot ahead of the head never yields
    assign head_link.value = '0;
    assign head_link.valid = 1'b1;
    assign head_link.yield = 1'b0;

    assign tail_link.value = '0;
    assign tail_link.valid = 1'b0;
    assign tail_link.yield = 1'b1;

    genvar i;
    generate
        for (i = 0; i < mhpq_pkg::CAPACITY; i++)
        begin : g_cell
            mhpq_pkg::link_t left_in;
            mhpq_pkg::link_t right_in;

            if (i == 0)
            begin : g_head
                assign left_in = head_link;
            end
            else
            begin : g_mid
                assign left_in = cell_links[i-1];
            end

            if (i == mhpq_pkg::CAPACITY - 1)
            begin : g_tail
                assign right_in = tail_link;
            end
            else
            begin : g_body
                assign right_in = cell_links[i+1];
            end

            mhpq_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cell_cmd),
                .left  (left_in),
                .right (right_in),
                .self  (cell_links[i])
            );
        end
    endgenerate

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign is_empty    = no_entry;
    assign entry_count = count_reg;
    assign status      = status_reg;
    assign top_value   = no_entry ? '0 : cell_links[0].value;

endmodule
